// ===== sv/wcbr_pkg.sv =====
// shared types, constants and register codes of the waveform column bar renderer
package wcbr_pkg;

  localparam int DISPLAY_HEIGHT_DEF = 8;
  localparam int DISPLAY_WIDTH_DEF  = 16;

  localparam int ROW_SHIFT = 24;
  localparam int ONE_ROW   = 16777216;
  localparam int HALF_ROW  = 8388608;

  localparam int NUM_W     = 32 + ROW_SHIFT;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // signed display row plus headroom for one row past either end
  localparam int ROW_W = 10;
  localparam int POS_W = 33;
  localparam int ROWNUM_W = POS_W - ROW_SHIFT;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_CENTRE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SPAN   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLOUR = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RED    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GREEN  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BLUE   = 3'd5;

  localparam logic signed [31:0] CENTRE_RST = 32'sd0;
  localparam logic [31:0]        SPAN_RST   = 32'h8000_0000;
  localparam logic [7:0]         LEVEL_RST  = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SAT,
    ST_WIDEN,
    ST_BOUNDS,
    ST_ROWS
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic sat;
    logic widen;
    logic bounds;
    logic issue;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic row_empty;
    logic row_last;
  } stat_t;

endpackage

// ===== sv/waveform_column_bar_renderer_top.sv =====
// top level of the waveform column bar renderer: configuration registers and block wiring
//
// An item is taken when start is high and busy is low. An item with has_data low
// or a column at or beyond DISPLAY_WIDTH is taken without busy going high and
// draws nothing. Otherwise the two peak positions come from two bit-serial
// dividers working side by side, followed by the saturation, widening and
// clipping states, and then one cycle per lit row; busy stays high until the
// last row is issued, or none is left. Pixels come out bottom row first, through
// the shading pipeline registers after their row is issued, each as a one-cycle
// strobe with the pixel word; the receiver cannot hold them off, and last marks
// the final pixel of a bar. A bar that covers no display row gives no pixels. The
// user must write the registers (wr_en, wr_index, wr_data) only while idle and
// once the last pixel of the previous bar has come out; the block does not enforce it.
module waveform_column_bar_renderer_top #(
  parameter int DISPLAY_HEIGHT = wcbr_pkg::DISPLAY_HEIGHT_DEF,
  parameter int DISPLAY_WIDTH  = wcbr_pkg::DISPLAY_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [3:0]                     column,
  input  logic                           has_data,
  input  logic signed [31:0]             col_min,
  input  logic signed [31:0]             col_max,
  input  logic                           wr_en,
  input  logic [wcbr_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [31:0]                    wr_data,
  output logic                           strobe,
  output logic [3:0]                     out_column,
  output logic [2:0]                     pixel_row,
  output logic [7:0]                     red,
  output logic [7:0]                     green,
  output logic [7:0]                     blue,
  output logic                           last
);

  logic signed [31:0] value_centre;
  logic [31:0]        value_span;
  logic               colour_enable;
  logic [7:0]         red_level;
  logic [7:0]         green_level;
  logic [7:0]         blue_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_centre  <= wcbr_pkg::CENTRE_RST;
      value_span    <= wcbr_pkg::SPAN_RST;
      colour_enable <= 1'b1;
      red_level     <= wcbr_pkg::LEVEL_RST;
      green_level   <= wcbr_pkg::LEVEL_RST;
      blue_level    <= wcbr_pkg::LEVEL_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        wcbr_pkg::REG_CENTRE: value_centre  <= $signed(wr_data);
        wcbr_pkg::REG_SPAN:   value_span    <= wr_data;
        wcbr_pkg::REG_COLOUR: colour_enable <= wr_data[0];
        wcbr_pkg::REG_RED:    red_level     <= wr_data[7:0];
        wcbr_pkg::REG_GREEN:  green_level   <= wr_data[7:0];
        wcbr_pkg::REG_BLUE:   blue_level    <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  wcbr_pkg::cmd_t  cmd;
  wcbr_pkg::stat_t stat;

  wcbr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  wcbr_dp #(
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
    .DISPLAY_WIDTH  (DISPLAY_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .column        (column),
    .has_data      (has_data),
    .col_min       (col_min),
    .col_max       (col_max),
    .value_centre  (value_centre),
    .value_span    (value_span),
    .colour_enable (colour_enable),
    .red_level     (red_level),
    .green_level   (green_level),
    .blue_level    (blue_level),
    .strobe        (strobe),
    .out_column    (out_column),
    .pixel_row     (pixel_row),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .last          (last)
  );

endmodule

// ===== sv/wcbr_div.sv =====
// bit-serial signed divider: offset shifted up by 24 bits over the span, saturated to 32 bits
module wcbr_div (
  input  logic               clk,
  input  logic               load,
  input  logic               step,
  input  logic signed [31:0] offset,
  input  logic [31:0]        span,
  output logic signed [31:0] quot
);

  logic                        neg;
  logic                        zero;
  logic [wcbr_pkg::NUM_W-1:0]  acc;
  logic [31:0]                 rem;

  logic [31:0] mag;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        ge;
  logic [31:0] rem_next;

  assign mag      = offset[31] ? (~offset + 32'd1) : offset;
  assign rem_sh   = {rem, acc[wcbr_pkg::NUM_W-1]};
  assign rem_sub  = rem_sh - {1'b0, span};
  assign ge       = rem_sh >= {1'b0, span};
  assign rem_next = ge ? rem_sub[31:0] : rem_sh[31:0];

  always_ff @(posedge clk) begin
    if (load) begin
      neg  <= offset[31];
      zero <= (offset == 32'sd0);
      acc  <= {mag, {wcbr_pkg::ROW_SHIFT{1'b0}}};
      rem  <= 32'd0;
    end else if (step) begin
      acc <= {acc[wcbr_pkg::NUM_W-2:0], ge};
      rem <= rem_next;
    end
  end

  // zero span leaves an all-ones quotient, which saturates the right way
  always_comb begin
    if (zero) begin
      quot = 32'sd0;
    end else if (!neg) begin
      quot = (|acc[wcbr_pkg::NUM_W-1:31]) ? 32'sh7FFF_FFFF : $signed(acc[31:0]);
    end else begin
      if ((|acc[wcbr_pkg::NUM_W-1:32]) || (acc[31] && (|acc[30:0]))) begin
        quot = 32'sh8000_0000;
      end else begin
        quot = $signed(~acc[31:0] + 32'd1);
      end
    end
  end

endmodule

// ===== sv/wcbr_ctrl.sv =====
// sequencer: division steps, position fix-up, then one row issued per cycle
module wcbr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  wcbr_pkg::stat_t stat,
  output logic            busy,
  output wcbr_pkg::cmd_t  cmd
);

  localparam logic [wcbr_pkg::CNT_W-1:0] CNT_LAST = wcbr_pkg::CNT_W'(wcbr_pkg::DIV_STEPS - 1);

  wcbr_pkg::state_t          state;
  wcbr_pkg::state_t          state_next;
  logic [wcbr_pkg::CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wcbr_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        cnt <= '0;
      end else if (cmd.step) begin
        cnt <= cnt + wcbr_pkg::CNT_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      wcbr_pkg::ST_IDLE: begin
        if (start && !stat.skip) state_next = wcbr_pkg::ST_DIV;
      end
      wcbr_pkg::ST_DIV: begin
        if (cnt == CNT_LAST) state_next = wcbr_pkg::ST_SAT;
      end
      wcbr_pkg::ST_SAT:    state_next = wcbr_pkg::ST_WIDEN;
      wcbr_pkg::ST_WIDEN:  state_next = wcbr_pkg::ST_BOUNDS;
      wcbr_pkg::ST_BOUNDS: state_next = wcbr_pkg::ST_ROWS;
      wcbr_pkg::ST_ROWS: begin
        if (stat.row_empty || stat.row_last) state_next = wcbr_pkg::ST_IDLE;
      end
      default: state_next = wcbr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      wcbr_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start && !stat.skip;
      end
      wcbr_pkg::ST_DIV:    cmd.step   = 1'b1;
      wcbr_pkg::ST_SAT:    cmd.sat    = 1'b1;
      wcbr_pkg::ST_WIDEN:  cmd.widen  = 1'b1;
      wcbr_pkg::ST_BOUNDS: cmd.bounds = 1'b1;
      wcbr_pkg::ST_ROWS:   cmd.issue  = !stat.row_empty;
      default: busy = 1'b1;
    endcase
  end

  a_div_to_sat: assert property (@(posedge clk) disable iff (rst)
    (state == wcbr_pkg::ST_DIV && cnt == CNT_LAST) |=> state == wcbr_pkg::ST_SAT)
    else $error("division did not end after the last step");

  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> ($past(start) && $past(cmd.load)))
    else $error("went busy without an accepted start");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (!cmd.step && !cmd.issue && !cmd.sat))
    else $error("datapath command while idle");

endmodule

// ===== sv/wcbr_dp.sv =====
// datapath: two dividers, bar widening and clipping, three-stage pixel shading pipeline
module wcbr_dp #(
  parameter int DISPLAY_HEIGHT = wcbr_pkg::DISPLAY_HEIGHT_DEF,
  parameter int DISPLAY_WIDTH  = wcbr_pkg::DISPLAY_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  wcbr_pkg::cmd_t     cmd,
  output wcbr_pkg::stat_t    stat,
  input  logic [3:0]         column,
  input  logic               has_data,
  input  logic signed [31:0] col_min,
  input  logic signed [31:0] col_max,
  input  logic signed [31:0] value_centre,
  input  logic [31:0]        value_span,
  input  logic               colour_enable,
  input  logic [7:0]         red_level,
  input  logic [7:0]         green_level,
  input  logic [7:0]         blue_level,
  output logic               strobe,
  output logic [3:0]         out_column,
  output logic [2:0]         pixel_row,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic               last
);

  localparam int HALF_H = DISPLAY_HEIGHT / 2;
  localparam int RW     = wcbr_pkg::ROW_W;
  localparam int PW     = wcbr_pkg::POS_W;
  localparam int NW     = wcbr_pkg::ROWNUM_W;
  localparam logic signed [RW-1:0] ROW_BOTTOM = RW'(-HALF_H);
  localparam logic signed [RW-1:0] ROW_TOP    = RW'(HALF_H - 1);
  localparam logic signed [PW-1:0] ONE_ROW_P  = PW'(wcbr_pkg::ONE_ROW);
  localparam logic signed [PW-1:0] HALF_ROW_P = PW'(wcbr_pkg::HALF_ROW);

  logic signed [31:0] off_lo;
  logic signed [31:0] off_hi;
  logic signed [31:0] q_lo;
  logic signed [31:0] q_hi;

  logic [3:0]           col_reg;
  logic signed [PW-1:0] lo;
  logic signed [PW-1:0] hi;
  logic signed [NW-1:0] lo_row;
  logic signed [NW-1:0] hi_row;
  logic signed [RW-1:0] y;
  logic signed [RW-1:0] y_end;

  assign off_lo = col_min - value_centre;
  assign off_hi = col_max - value_centre;

  wcbr_div u_div_lo (
    .clk    (clk),
    .load   (cmd.load),
    .step   (cmd.step),
    .offset (off_lo),
    .span   (value_span),
    .quot   (q_lo)
  );

  wcbr_div u_div_hi (
    .clk    (clk),
    .load   (cmd.load),
    .step   (cmd.step),
    .offset (off_hi),
    .span   (value_span),
    .quot   (q_hi)
  );

  // widening of a bar thinner than one row around its midpoint
  logic signed [PW-1:0] height;
  logic                 thin;
  logic signed [31:0]   mid;
  logic signed [PW-1:0] mid_x;

  assign height = hi - lo;
  assign thin   = height < ONE_ROW_P;
  assign mid    = $signed(hi[PW-1:1]) + $signed(lo[PW-1:1]);
  assign mid_x  = {mid[31], mid};

  // clipping to the display
  logic signed [NW-1:0] lo_row_c;
  logic signed [NW-1:0] hi_row_c;
  logic signed [RW-1:0] lo_row_x;
  logic signed [RW-1:0] hi_row_x;
  logic signed [RW-1:0] y_start_c;
  logic signed [RW-1:0] y_end_c;

  assign lo_row_c  = lo[PW-1:wcbr_pkg::ROW_SHIFT];
  assign hi_row_c  = hi[PW-1:wcbr_pkg::ROW_SHIFT];
  assign lo_row_x  = RW'(lo_row_c);
  assign hi_row_x  = RW'(hi_row_c);
  assign y_start_c = (lo_row_x < ROW_BOTTOM) ? ROW_BOTTOM : lo_row_x;
  assign y_end_c   = (hi_row_x > ROW_TOP) ? ROW_TOP : hi_row_x;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_reg <= column;
    end
    if (cmd.sat) begin
      lo <= PW'(q_lo);
      hi <= PW'(q_hi);
    end else if (cmd.widen && thin) begin
      lo <= mid_x - HALF_ROW_P;
      hi <= mid_x + HALF_ROW_P;
    end
    if (cmd.bounds) begin
      lo_row <= lo_row_c;
      hi_row <= hi_row_c;
      y      <= y_start_c;
      y_end  <= y_end_c;
    end else if (cmd.issue) begin
      y <= y + RW'(1);
    end
  end

  assign stat.skip      = !has_data || ({28'd0, column} >= 32'(DISPLAY_WIDTH));
  assign stat.row_empty = y > y_end;
  assign stat.row_last  = y == y_end;

  // coverage of the current row
  logic [7:0] frac_lo;
  logic [7:0] frac_hi;
  logic [8:0] amount;

  assign frac_lo = lo[wcbr_pkg::ROW_SHIFT-1:wcbr_pkg::ROW_SHIFT-8];
  assign frac_hi = hi[wcbr_pkg::ROW_SHIFT-1:wcbr_pkg::ROW_SHIFT-8];

  always_comb begin
    if (y == RW'(lo_row)) begin
      amount = colour_enable ? (9'd256 - {1'b0, frac_lo}) : (9'd128 - {2'b0, frac_lo[7:1]});
    end else if (y < RW'(hi_row)) begin
      amount = colour_enable ? 9'd256 : 9'd128;
    end else begin
      amount = colour_enable ? {1'b0, frac_hi} : {2'b0, frac_hi[7:1]};
    end
  end

  // stage 1: coverage, stage 2: square, stage 3: channel scaling
  logic       s1_valid;
  logic       s1_last;
  logic [3:0] s1_col;
  logic [2:0] s1_row;
  logic [8:0] s1_amount;
  logic       s2_valid;
  logic       s2_last;
  logic [3:0] s2_col;
  logic [2:0] s2_row;
  logic [8:0] s2_v;

  logic [RW-1:0] row_sum;
  logic [17:0]   sq;
  logic [16:0]   prod_r;
  logic [16:0]   prod_g;
  logic [16:0]   prod_b;

  assign row_sum = y + RW'(HALF_H);
  assign sq      = 18'(s1_amount) * 18'(s1_amount);
  assign prod_r  = 17'(s2_v) * 17'(red_level);
  assign prod_g  = 17'(s2_v) * 17'(green_level);
  assign prod_b  = 17'(s2_v) * 17'(blue_level);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
      strobe   <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_last   <= stat.row_last;
    s1_col    <= col_reg;
    s1_row    <= row_sum[2:0];
    s1_amount <= amount;

    s2_last <= s1_last;
    s2_col  <= s1_col;
    s2_row  <= s1_row;
    s2_v    <= sq[16:8];

    last       <= s2_last;
    out_column <= s2_col;
    pixel_row  <= s2_row;
    if (colour_enable) begin
      red   <= prod_r[16] ? 8'd255 : prod_r[15:8];
      green <= prod_g[16] ? 8'd255 : prod_g[15:8];
      blue  <= prod_b[16] ? 8'd255 : prod_b[15:8];
    end else begin
      red   <= s2_v[7:0];
      green <= s2_v[7:0];
      blue  <= s2_v[7:0];
    end
  end

  a_issue_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !stat.row_empty)
    else $error("row issued past the clipped stop");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("pixel word right after the final pixel of a bar");

  a_grey_equal: assert property (@(posedge clk) disable iff (rst)
    (strobe && !colour_enable) |-> (red == green && green == blue && red <= 8'd64))
    else $error("grey pixel with unequal or too bright channels");

endmodule

// ===== sim/bar_pixel_checker.sv =====
// checker for the waveform column bar renderer: predicts each column's lit pixels and compares them
module bar_pixel_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic [3:0]                     column,
  input  logic                           has_data,
  input  logic signed [31:0]             col_min,
  input  logic signed [31:0]             col_max,
  input  logic                           wr_en,
  input  logic [wcbr_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [31:0]                    wr_data,
  input  logic                           strobe,
  input  logic [3:0]                     out_column,
  input  logic [2:0]                     pixel_row,
  input  logic [7:0]                     red,
  input  logic [7:0]                     green,
  input  logic [7:0]                     blue,
  input  logic                           last,
  output int                             mismatches,
  output int                             outstanding
);

  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;
  localparam longint HALF_HEIGHT = wcbr_pkg::DISPLAY_HEIGHT_DEF / 2;

  typedef struct packed {
    logic [3:0] col;
    logic [2:0] row;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       last;
  } pixel_t;

  pixel_t pixel_q[$];
  int bad = 0;

  logic signed [31:0] centre;
  logic [31:0]        span;
  logic               colour_on;
  logic [7:0]         red_lvl;
  logic [7:0]         green_lvl;
  logic [7:0]         blue_lvl;

  assign mismatches = bad;

  // 8.24 row position of one peak, saturated to 32 bits signed
  function automatic longint row_position(logic signed [31:0] peak);
    logic signed [31:0] offset;
    longint num;
    longint q;
    offset = peak - centre;
    num = longint'(offset) * wcbr_pkg::ONE_ROW;
    if (span == 32'd0) begin
      q = (offset > 0) ? POS_MAX : ((offset < 0) ? POS_MIN : 64'sd0);
    end else begin
      q = num / longint'({32'b0, span});
    end
    if (q > POS_MAX) q = POS_MAX;
    if (q < POS_MIN) q = POS_MIN;
    return q;
  endfunction

  function automatic logic [7:0] channel(longint v, logic [7:0] lvl);
    longint c;
    c = colour_on ? ((v * lvl) >>> 8) : v;
    return (c > 255) ? 8'd255 : 8'(c);
  endfunction

  function automatic void render_bar(logic [3:0] col, logic hd, logic signed [31:0] mn,
                                     logic signed [31:0] mx);
    longint lo, hi, mid, lo_row, hi_row, y_first, y_end, bright, frac, amount, v;
    pixel_t px;
    if (!hd || col >= wcbr_pkg::DISPLAY_WIDTH_DEF) return;
    lo = row_position(mn);
    hi = row_position(mx);
    // thin bars become exactly one row around their midpoint
    if (hi - lo < wcbr_pkg::ONE_ROW) begin
      mid = (hi >>> 1) + (lo >>> 1);
      hi = mid + wcbr_pkg::HALF_ROW;
      lo = mid - wcbr_pkg::HALF_ROW;
    end
    lo_row = lo >>> wcbr_pkg::ROW_SHIFT;
    hi_row = hi >>> wcbr_pkg::ROW_SHIFT;
    y_first = (lo_row < -HALF_HEIGHT) ? -HALF_HEIGHT : lo_row;
    y_end = (hi_row + 1 > HALF_HEIGHT) ? HALF_HEIGHT : hi_row + 1;
    bright = colour_on ? 256 : 128;
    for (longint y = y_first; y < y_end; y++) begin
      if (y == lo_row) begin
        frac = (lo - y * wcbr_pkg::ONE_ROW) >>> 16;
        amount = bright - ((frac * bright) >>> 8);
      end else if (y < hi_row) begin
        amount = bright;
      end else begin
        frac = (hi - y * wcbr_pkg::ONE_ROW) >>> 16;
        amount = (frac * bright) >>> 8;
      end
      if (amount < 0) amount = 0;
      v = (amount * amount) >>> 8;
      px.col = col;
      px.row = 3'(y + HALF_HEIGHT);
      px.r = channel(v, red_lvl);
      px.g = channel(v, green_lvl);
      px.b = channel(v, blue_lvl);
      px.last = (y == y_end - 1);
      pixel_q.push_back(px);
    end
  endfunction

  function automatic void note_mismatch(string what, pixel_t exp, pixel_t got);
    string exp_s;
    string got_s;
    if (bad < 10) begin
      exp_s = $sformatf("col %0d row %0d rgb %0d/%0d/%0d last %0d",
                        exp.col, exp.row, exp.r, exp.g, exp.b, exp.last);
      got_s = $sformatf("col %0d row %0d rgb %0d/%0d/%0d last %0d",
                        got.col, got.row, got.r, got.g, got.b, got.last);
      $display("%s: expected %s, got %s", what, exp_s, got_s);
    end
    bad++;
  endfunction

  always @(posedge clk) begin
    pixel_t got;
    pixel_t exp;
    if (rst) begin
      centre = wcbr_pkg::CENTRE_RST;
      span = wcbr_pkg::SPAN_RST;
      colour_on = 1'b1;
      red_lvl = wcbr_pkg::LEVEL_RST;
      green_lvl = wcbr_pkg::LEVEL_RST;
      blue_lvl = wcbr_pkg::LEVEL_RST;
      pixel_q.delete();
    end else begin
      if (strobe) begin
        got = '{out_column, pixel_row, red, green, blue, last};
        if (pixel_q.size() == 0) begin
          note_mismatch("pixel word with none pending", '0, got);
        end else begin
          exp = pixel_q.pop_front();
          if (got !== exp) note_mismatch("pixel word mismatch", exp, got);
        end
      end
      if (wr_en) begin
        case (wr_index)
          wcbr_pkg::REG_CENTRE: centre = wr_data;
          wcbr_pkg::REG_SPAN:   span = wr_data;
          wcbr_pkg::REG_COLOUR: colour_on = wr_data[0];
          wcbr_pkg::REG_RED:    red_lvl = wr_data[7:0];
          wcbr_pkg::REG_GREEN:  green_lvl = wr_data[7:0];
          wcbr_pkg::REG_BLUE:   blue_lvl = wr_data[7:0];
          default: ;
        endcase
      end
      if (start && !busy) render_bar(column, has_data, col_min, col_max);
    end
    outstanding <= pixel_q.size();
  end

endmodule

// ===== sim/waveform_column_bar_renderer_top_test.sv =====
// testbench top for the waveform column bar renderer: clock, reset, column stimulus and verdict
module waveform_column_bar_renderer_top_test;

  localparam int LIMIT_CYCLES = 300000;
  localparam int ITEMS_PER_PHASE = 36;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;

  logic                           clk;
  logic                           rst;
  logic                           start;
  logic                           busy;
  logic [3:0]                     column;
  logic                           has_data;
  logic signed [31:0]             col_min;
  logic signed [31:0]             col_max;
  logic                           wr_en;
  logic [wcbr_pkg::REG_IDX_W-1:0] wr_index;
  logic [31:0]                    wr_data;
  logic                           strobe;
  logic [3:0]                     out_column;
  logic [2:0]                     pixel_row;
  logic [7:0]                     red;
  logic [7:0]                     green;
  logic [7:0]                     blue;
  logic                           last;
  int                             mismatches;
  int                             outstanding;
  int                             cycle_count = 0;
  bit                             steady = 0;
  logic signed [31:0]             cur_centre;
  logic [31:0]                    cur_span;

  waveform_column_bar_renderer_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .column(column), .has_data(has_data), .col_min(col_min), .col_max(col_max),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .strobe(strobe), .out_column(out_column), .pixel_row(pixel_row),
    .red(red), .green(green), .blue(blue), .last(last)
  );

  bar_pixel_checker pixel_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .column(column), .has_data(has_data), .col_min(col_min), .col_max(col_max),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .strobe(strobe), .out_column(out_column), .pixel_row(pixel_row),
    .red(red), .green(green), .blue(blue), .last(last),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("waveform_column_bar_renderer_top_test NOT OK");
      $finish;
    end
  end

  // random hold-off of the next word, long enough to land on any phase of the block
  task automatic sender_gap();
    if (!steady && $urandom_range(0, 99) < 13) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 70)) @(posedge clk);
    end
  endtask

  task automatic send_column(logic [3:0] col, logic hd, logic signed [31:0] mn,
                             logic signed [31:0] mx);
    sender_gap();
    start <= 1'b1;
    column <= col;
    has_data <= hd;
    col_min <= mn;
    col_max <= mx;
    do @(posedge clk); while (busy);
  endtask

  // wait until the block is idle and no pixel is pending
  task automatic drain(int max_cycles);
    int quiet;
    int n;
    quiet = 0;
    n = 0;
    start <= 1'b0;
    while (quiet < 8 && n < max_cycles) begin
      @(posedge clk);
      n++;
      if (!busy && outstanding == 0) quiet++;
      else quiet = 0;
    end
  endtask

  task automatic write_reg(logic [wcbr_pkg::REG_IDX_W-1:0] idx, logic [31:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_config(logic signed [31:0] centre, logic [31:0] span, logic colour,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b);
    drain(2000);
    write_reg(wcbr_pkg::REG_CENTRE, centre);
    write_reg(wcbr_pkg::REG_SPAN, span);
    write_reg(wcbr_pkg::REG_COLOUR, {31'b0, colour});
    write_reg(wcbr_pkg::REG_RED, {24'b0, r});
    write_reg(wcbr_pkg::REG_GREEN, {24'b0, g});
    write_reg(wcbr_pkg::REG_BLUE, {24'b0, b});
    wr_en <= 1'b0;
    cur_centre = centre;
    cur_span = span;
  endtask

  // sample value at a given number of 1/64 rows from the centre
  function automatic logic signed [31:0] peak_at(int sixty_fourths);
    longint offset;
    offset = longint'(sixty_fourths) * longint'({32'b0, cur_span}) / 64;
    if (offset > POS_MAX) offset = POS_MAX;
    if (offset < POS_MIN) offset = POS_MIN;
    return cur_centre + 32'(offset);
  endfunction

  function automatic logic signed [31:0] corner_value();
    case ($urandom_range(0, 4))
      0: return S_MIN;
      1: return S_MAX;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return cur_centre;
    endcase
  endfunction

  task automatic random_phase(int p);
    int drawn;
    int kind;
    int a;
    int b;
    int t;
    logic [31:0] span;
    span = (32'd1 << $urandom_range(16, 29)) + $urandom_range(0, 65535);
    if (p == 3) span = 32'd1;
    if (p == 4) span = 32'hFFFF_FFFF;
    apply_config((p == 1) ? S_MIN : ((p == 2) ? S_MAX : $urandom),
                 span,
                 (p % 2 == 0) ? 1'b1 : 1'b0,
                 (p == 1) ? 8'd0 : ((p == 2) ? 8'd255 : 8'($urandom)),
                 (p == 1) ? 8'd0 : ((p == 2) ? 8'd255 : 8'($urandom)),
                 (p == 1) ? 8'd0 : ((p == 2) ? 8'd255 : 8'($urandom)));
    steady = (p == 3);
    drawn = 0;
    while (drawn < ITEMS_PER_PHASE) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        send_column(4'($urandom), 1'b0, $urandom, $urandom);
      end else begin
        if (kind < 75) begin
          // mostly well-formed bar with one peak within five rows of the centre
          a = int'($urandom_range(0, 640)) - 320;
          b = a + int'($urandom_range(0, 400)) - 40;
          if ($urandom_range(0, 3) == 0) begin
            a = a & ~63;
            b = b & ~63;
          end
          if ($urandom_range(0, 9) == 0) begin
            t = a;
            a = b;
            b = t;
          end
          send_column(4'($urandom), 1'b1, peak_at(a), peak_at(b));
        end else if (kind < 90) begin
          send_column(4'($urandom), 1'b1, $urandom, $urandom);
        end else begin
          send_column(4'($urandom), 1'b1, corner_value(), corner_value());
        end
        drawn++;
      end
    end
    steady = 0;
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    column <= '0;
    has_data <= 1'b0;
    col_min <= '0;
    col_max <= '0;
    wr_en <= 1'b0;
    wr_index <= wcbr_pkg::REG_CENTRE;
    wr_data <= '0;
    cur_centre = wcbr_pkg::CENTRE_RST;
    cur_span = wcbr_pkg::SPAN_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one row is 2^31 sample units
    send_column(4'd0, 1'b0, $urandom, $urandom);
    send_column(4'd15, 1'b1, S_MIN, S_MAX);
    send_column(4'd5, 1'b1, 32'sd0, 32'sd0);
    send_column(4'd7, 1'b1, S_MAX, S_MIN);
    send_column(4'd15, 1'b1, -32'sd1, -32'sd1);

    // grey, one row is 2^28
    apply_config(32'sd0, 32'h1000_0000, 1'b0, 8'h12, 8'h34, 8'h56);
    send_column(4'd1, 1'b1, 32'sh5000_0000, 32'sh6000_0000);
    send_column(4'd2, 1'b1, -32'sh6000_0000, -32'sh5000_0000);
    send_column(4'd3, 1'b1, S_MIN, S_MAX);
    send_column(4'd4, 1'b1, 32'sh1000_0000, 32'sh3000_0000);
    send_column(4'd6, 1'b1, 32'sh0800_0000, 32'sh0800_0000);

    // centre at the top so the offsets wrap
    apply_config(S_MAX, 32'h1000_0000, 1'b1, 8'd255, 8'd0, 8'd128);
    send_column(4'd8, 1'b1, S_MIN, S_MIN + 32'sh1000_0000);
    send_column(4'd9, 1'b1, -32'sd1, 32'sd0);

    // span of one, so offsets outside -128 to 127 saturate the quotients
    apply_config(32'sd0, 32'd1, 1'b1, 8'd200, 8'd100, 8'd50);
    send_column(4'd10, 1'b1, -32'sd3, 32'sd5);
    send_column(4'd11, 1'b1, 32'sd0, 32'sd0);
    send_column(4'd12, 1'b1, 32'sd0, 32'sd200);
    send_column(4'd13, 1'b1, S_MAX, S_MAX);
    send_column(4'd14, 1'b1, S_MIN, S_MIN);

    // zero span
    apply_config(32'sd0, 32'd0, 1'b0, 8'd255, 8'd255, 8'd255);
    send_column(4'd0, 1'b1, -32'sd7, 32'sd9);
    send_column(4'd1, 1'b1, 32'sd0, 32'sd0);
    send_column(4'd2, 1'b1, 32'sd0, 32'sd5);

    apply_config(32'sd0, 32'hFFFF_FFFF, 1'b1, 8'd255, 8'd255, 8'd255);
    send_column(4'd3, 1'b1, S_MIN, S_MAX);

    for (int p = 0; p < 6; p++) random_phase(p);

    drain(5000);
    if (mismatches == 0 && outstanding == 0) begin
      $display("waveform_column_bar_renderer_top_test OK");
    end else begin
      $display("waveform_column_bar_renderer_top_test NOT OK");
    end
    $finish;
  end

endmodule
